/* rtl/core/zlft_pkg.sv */
// ----------------------------------------------------------------------------
// zlft_pkg
// Shared types and constants for the zoom level fade table.
// ----------------------------------------------------------------------------
`default_nettype none

package zlft_pkg;

  localparam int LEVELS_DEF    = 256;
  localparam int TIME_BITS_DEF = 32;

  localparam logic [7:0]  FULL_OPACITY = 8'd255;
  localparam logic [15:0] FADE_RESET   = 16'd300;

  localparam logic CMD_RECORD = 1'b0;
  localparam logic CMD_READ   = 1'b1;

endpackage

`default_nettype wire

/* rtl/core/zoom_level_fade_table_unit.sv */
// ----------------------------------------------------------------------------
// zoom_level_fade_table_unit
// Per-level opacity table with time-based fade in/out and single-entry read.
//
//  channel  | dir | handshake        | payload
//  ---------+-----+------------------+------------------------------------------
//  s_*      | in  | tvalid / tready  | tdata: timestamp, zoom_q8, read_level
//           |     |                  | tuser: command
//  m_*      | out | tvalid / tready  | tdata: opacity;  tuser: needs_animation
//  cfg      | in  | fade_duration_we | fade_duration_data
//
// A read item goes from accept through the read, evaluate and finishing states.
// A record item walks all LEVELS entries, each through read, evaluate and
// write-back, with the shared restoring divider in between when the fade is
// still running, and then hands off the result from the finishing state.
// After reset a clearing pass zeroes the tables; s_tready stays low during it.
// Input is taken only while the sequencer is idle; a finished result waits in
// the output register while m_tready is low.
// ----------------------------------------------------------------------------
`default_nettype none

module zoom_level_fade_table_unit
  import zlft_pkg::*;
#(
  parameter int LEVELS    = LEVELS_DEF,
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        fade_duration_we,
  input  wire logic [15:0] fade_duration_data,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [55:0] s_tdata,   // timestamp[31:0], zoom_q8[44:32], read_level[52:45]
  input  wire logic        s_tuser,   // command
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata,   // opacity[7:0]
  output logic             m_tuser    // needs_animation
);

  localparam int LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam logic [LW-1:0] LAST = LW'(LEVELS - 1);

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_RD, ST_EVAL, ST_DIV, ST_WB, ST_DONE
  } state_t;

  state_t state;

  // table storage
  logic [7:0]           mem_op [LEVELS];
  logic [7:0]           mem_st [LEVELS];
  logic [TIME_BITS-1:0] mem_ct [LEVELS];

  logic [LW-1:0]        addr;
  logic [7:0]           rd_op, rd_st;
  logic [TIME_BITS-1:0] rd_ct;

  logic                 wr_en;
  logic [7:0]           wr_op, wr_st;
  logic [TIME_BITS-1:0] wr_ct;

  // config and persistent state
  logic [15:0]          fade_duration;
  logic                 first_record;
  logic [LW-1:0]        prior_level;
  logic [TIME_BITS-1:0] level_change_time;
  logic [TIME_BITS-1:0] last_time;

  // per-item working registers
  logic                 cmd;
  logic [TIME_BITS-1:0] now;
  logic [LW-1:0]        level;
  logic                 rl_ok;
  logic [7:0]           res_op;
  logic [7:0]           st_r, delta;
  logic [TIME_BITS-1:0] ct_r;
  logic [15:0]          rem;
  logic [7:0]           nlow;
  logic [2:0]           dcnt;

  // input decode
  logic [TIME_BITS-1:0] in_now;
  logic [16:0]          zq10;
  logic [8:0]           lv9;
  logic [LW-1:0]        in_level;
  logic [7:0]           in_rl;

  assign in_now = TIME_BITS'(s_tdata[31:0]);
  assign zq10   = 17'(s_tdata[44:32]) * 17'd10;
  assign lv9    = zq10[16:8];
  assign in_level = (32'(lv9) > 32'(LEVELS - 1)) ? LAST : LW'(lv9);
  assign in_rl  = s_tdata[52:45];

  // per-entry evaluation (first record seeding, crossing, elapsed time)
  logic [LW-1:0]        lo, hi;
  logic                 crossed, at_or_below;
  logic [TIME_BITS-1:0] ct_eff, elapsed;
  logic [7:0]           op_eff, st_eff;
  logic                 full_fade;
  logic [23:0]          num;

  assign lo = (level < prior_level) ? level : prior_level;
  assign hi = (level < prior_level) ? prior_level : level;
  assign crossed     = (addr > lo) && (addr <= hi);
  assign at_or_below = (addr <= level);

  always_comb begin
    op_eff = rd_op;
    if (first_record && at_or_below) begin
      op_eff = FULL_OPACITY;
    end
    ct_eff = (first_record || crossed) ? now : rd_ct;
    st_eff = crossed ? op_eff : rd_st;
  end

  assign elapsed   = now - ct_eff;
  assign full_fade = (fade_duration == 16'd0) || (elapsed >= TIME_BITS'(fade_duration));
  // elapsed * 255, only used when elapsed < fade_duration
  assign num = {elapsed[15:0], 8'd0} - 24'(elapsed[15:0]);

  // divider step
  logic [16:0] trial;
  logic        fits;
  assign trial = {rem, nlow[7]};
  assign fits  = trial >= {1'b0, fade_duration};

  // write-back value
  logic [8:0] up_sum;
  assign up_sum = 9'(st_r) + 9'(delta);

  always_comb begin
    wr_en = 1'b0;
    wr_op = 8'd0;
    wr_st = 8'd0;
    wr_ct = '0;
    if (state == ST_CLEAR) begin
      wr_en = 1'b1;
    end else if (state == ST_WB) begin
      wr_en = 1'b1;
      wr_st = st_r;
      wr_ct = ct_r;
      if (addr <= level) begin
        wr_op = up_sum[8] ? FULL_OPACITY : up_sum[7:0];
      end else begin
        wr_op = (delta >= st_r) ? 8'd0 : st_r - delta;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_op[addr] <= wr_op;
      mem_st[addr] <= wr_st;
      mem_ct[addr] <= wr_ct;
    end
    rd_op <= mem_op[addr];
    rd_st <= mem_st[addr];
    rd_ct <= mem_ct[addr];
  end

  logic anim;
  logic [TIME_BITS-1:0] gap;
  assign gap  = last_time - level_change_time;
  assign anim = gap < TIME_BITS'(fade_duration);

  assign s_tready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_CLEAR;
      addr              <= '0;
      fade_duration     <= FADE_RESET;
      first_record      <= 1'b1;
      prior_level       <= '0;
      level_change_time <= '0;
      last_time         <= '0;
      m_tvalid          <= 1'b0;
    end else begin
      if (fade_duration_we) begin
        fade_duration <= fade_duration_data;
      end
      // output register: load a finished item, or drop the one taken
      if ((state == ST_DONE) && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
        m_tdata  <= res_op;
        m_tuser  <= anim;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          if (addr == LAST) begin
            addr  <= '0;
            state <= ST_IDLE;
          end else begin
            addr <= addr + 1'b1;
          end
        end
        ST_IDLE: begin
          if (s_tvalid) begin
            cmd    <= s_tuser;
            now    <= in_now;
            level  <= in_level;
            res_op <= 8'd0;
            rl_ok  <= 32'(in_rl) < LEVELS;
            addr   <= (s_tuser == CMD_READ) ? LW'(in_rl) : '0;
            state  <= ST_RD;
          end
        end
        ST_RD: state <= ST_EVAL;
        ST_EVAL: begin
          if (cmd == CMD_READ) begin
            res_op <= rl_ok ? rd_op : 8'd0;
            state  <= ST_DONE;
          end else begin
            st_r <= st_eff;
            ct_r <= ct_eff;
            if (full_fade) begin
              delta <= FULL_OPACITY;
              state <= ST_WB;
            end else begin
              rem   <= num[23:8];
              nlow  <= num[7:0];
              delta <= 8'd0;
              dcnt  <= 3'd7;
              state <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          rem   <= fits ? 16'(trial - {1'b0, fade_duration}) : trial[15:0];
          delta <= {delta[6:0], fits};
          nlow  <= {nlow[6:0], 1'b0};
          dcnt  <= dcnt - 1'b1;
          if (dcnt == 3'd0) begin
            state <= ST_WB;
          end
        end
        ST_WB: begin
          if (addr == LAST) begin
            addr         <= '0;
            first_record <= 1'b0;
            last_time    <= now;
            if (level != prior_level) begin
              prior_level       <= level;
              level_change_time <= now;
            end
            state <= ST_DONE;
          end else begin
            addr  <= addr + 1'b1;
            state <= ST_RD;
          end
        end
        ST_DONE: begin
          if (!m_tvalid || m_tready) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  // clearing pass follows reset, so no input is taken right after it
  a_clear_after_reset: assert property (@(posedge clk) rst |=> !s_tready)
    else $error("input taken during clearing pass");
  // one item at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("second item accepted while busy");
  // a new result is only raised from the finishing state
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == ST_DONE))
    else $error("result raised outside finishing state");
  // divider runs only on records
  a_div_record: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (cmd == CMD_RECORD))
    else $error("divider active on a read");
`endif

endmodule

`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for zoom_level_fade_table_unit. A behavioral copy of the
// opacity table predicts the opacity and needs-animation flag of every item.
// Record and read items are driven over the slave stream with random gaps and
// output stalls. The fade duration is stepped through zero, one, the reset
// value, random values and the maximum.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import zlft_pkg::*;

  localparam int NUM_LEVELS  = 256;
  localparam int STALL_LIMIT = 20000;  // idle cycles before the watchdog fires

  typedef struct packed {
    logic [7:0] opacity;
    logic       anim;
  } fade_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        fade_duration_we = 1'b0;
  logic [15:0] fade_duration_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [55:0] s_tdata = '0;   // timestamp[31:0], zoom_q8[44:32], read_level[52:45]
  logic        s_tuser = 1'b0; // command
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;        // opacity[7:0]
  logic        m_tuser;        // needs_animation

  zoom_level_fade_table_unit uut (
    .clk(clk), .rst(rst),
    .fade_duration_we(fade_duration_we), .fade_duration_data(fade_duration_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always #10 clk = ~clk;

  // -------------------------------------------------------------------------
  // Predicted table state
  // -------------------------------------------------------------------------
  logic [7:0]  lvl_opacity [NUM_LEVELS];
  logic [7:0]  lvl_start   [NUM_LEVELS];
  logic [31:0] lvl_stamp   [NUM_LEVELS];
  logic        awaiting_first;
  logic [7:0]  prev_level;
  logic [31:0] zoom_change_time;
  logic [31:0] latest_time;
  logic [15:0] fade_len;

  fade_result_t expected_results[$];
  int          error_count = 0;
  logic [31:0] clock_now = '0;   // nondecreasing timestamp source
  logic [7:0]  zoom_now_level = '0;

  // Sender / receiver idling controls
  bit          idle_off = 1'b0;     // no gaps on either side
  int          hold_off_cycles = 0; // long receiver stall request

  function automatic logic [7:0] fade_step(logic [31:0] elapsed);
    longint unsigned prod;
    if (fade_len == 0 || elapsed >= {16'd0, fade_len}) return FULL_OPACITY;
    prod = longint'(elapsed) * 255;
    return 8'(prod / fade_len);
  endfunction

  task automatic predict_record(logic [31:0] now, logic [12:0] zq);
    int unsigned lv, lo, hi, sum;
    logic [7:0] delta;
    lv = (int'(zq) * 10) >> 8;
    if (lv > NUM_LEVELS - 1) lv = NUM_LEVELS - 1;
    if (awaiting_first) begin
      // first frame seeds stamps and lights everything up to the level
      for (int z = 0; z < NUM_LEVELS; z++) lvl_stamp[z] = now;
      for (int z = 0; z <= lv; z++) lvl_opacity[z] = FULL_OPACITY;
      awaiting_first = 1'b0;
    end
    lo = (lv < prev_level) ? lv : prev_level;
    hi = (lv < prev_level) ? prev_level : lv;
    // crossed levels restart their fade from where they are now
    for (int z = lo + 1; z <= hi && z < NUM_LEVELS; z++) begin
      lvl_stamp[z] = now;
      lvl_start[z] = lvl_opacity[z];
    end
    for (int z = 0; z < NUM_LEVELS; z++) begin
      delta = fade_step(now - lvl_stamp[z]);
      if (z <= lv) begin
        sum = lvl_start[z] + delta;
        lvl_opacity[z] = (sum > 255) ? FULL_OPACITY : 8'(sum);
      end else begin
        lvl_opacity[z] = (delta >= lvl_start[z]) ? 8'd0 : lvl_start[z] - delta;
      end
    end
    if (lv != prev_level) begin
      prev_level = 8'(lv);
      zoom_change_time = now;
    end
    latest_time = now;
  endtask

  function automatic logic anim_pending();
    return (latest_time - zoom_change_time) < {16'd0, fade_len};
  endfunction

  // -------------------------------------------------------------------------
  // Driving helpers
  // -------------------------------------------------------------------------
  function automatic int pick_gap();
    int r;
    if (idle_off) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Send one item; prediction is made at the accepting edge.
  task automatic send_item(logic cmd, logic [31:0] ts, logic [12:0] zq, logic [7:0] rl);
    fade_result_t res;
    int gap;
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {3'b000, rl, zq, ts};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (cmd == CMD_RECORD) predict_record(ts, zq);
    res.opacity = (cmd == CMD_READ) ? lvl_opacity[rl] : 8'd0;
    res.anim    = anim_pending();
    expected_results.push_back(res);
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_record(logic [31:0] ts, logic [12:0] zq);
    send_item(CMD_RECORD, ts, zq, 8'($urandom));
    zoom_now_level = 8'(((int'(zq) * 10) >> 8) > 255 ? 255 : ((int'(zq) * 10) >> 8));
  endtask

  task automatic send_read(logic [7:0] rl);
    send_item(CMD_READ, 32'($urandom), 13'($urandom), rl);
  endtask

  // Sender pause until every result is back, then a few spare cycles.
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_fade(logic [15:0] val);
    drain();
    fade_duration_we   <= 1'b1;
    fade_duration_data <= val;
    @(posedge clk);
    fade_duration_we   <= 1'b0;
    fade_len = val;
    @(posedge clk);
  endtask

  function automatic logic [31:0] advance_time(logic [31:0] step);
    return (clock_now > 32'hFFFF_FFFF - step) ? 32'hFFFF_FFFF : clock_now + step;
  endfunction

  // -------------------------------------------------------------------------
  // Tests
  // -------------------------------------------------------------------------
  task automatic test_reads_after_reset();
    // empty table, flag from zero times against the reset duration
    send_read(8'd0);
    send_read(8'd255);
  endtask

  task automatic test_first_record();
    clock_now = 32'd1000;
    send_record(clock_now, 13'd640);   // level 25
    send_read(8'd0);                   // level 0 fades in from zero
    send_read(8'd25);
    send_read(8'd26);
    clock_now = advance_time(150);
    send_record(clock_now, 13'd640);
    send_read(8'd0);
    send_read(8'd10);
  endtask

  task automatic test_directed_extremes();
    send_record(clock_now, 13'd6553);  // top level
    send_read(8'd255);
    send_record(clock_now, 13'd0);     // crossing all the way down
    send_read(8'd200);
    clock_now = advance_time(32'h8000_0000);
    send_record(clock_now, 13'd1000);  // long elapsed clamps to full
    send_read(8'd39);
    set_fade(16'd0);                   // jumps straight to end values
    send_record(clock_now, 13'd3000);
    send_read(8'd117);
    send_read(8'd118);
    set_fade(16'hFFFF);
    clock_now = advance_time(1);
    send_record(clock_now, 13'd100);
    send_read(8'd3);
    send_read(8'd100);
  endtask

  // Frame sequences: time moves a bit, zoom drifts or jumps, reads in between.
  task automatic run_frames(int count);
    int r;
    logic [12:0] zq;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 20) begin
        r = $urandom_range(0, 99);
        if (r < 70) clock_now = advance_time($urandom_range(0, fade_len / 4 + 4));
        else if (r < 97) clock_now = advance_time($urandom_range(0, fade_len + 64));
        else clock_now = advance_time($urandom_range(1 << 16, 1 << 24));
        r = $urandom_range(0, 99);
        if (r < 60) zq = 13'((int'(zoom_now_level) * 256) / 10 + $urandom_range(0, 120));
        else zq = 13'($urandom_range(0, 6553));
        if (zq > 13'd6553) zq = 13'd6553;
        send_record(clock_now, zq);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 60) send_read(8'(int'(zoom_now_level) + $urandom_range(0, 6) - 3));
        else send_read(8'($urandom));
      end
    end
  endtask

  task automatic test_fade_settings();
    set_fade(16'd1);
    run_frames(180);
    set_fade(16'd300);
    idle_off = 1'b1;          // a stretch with back-to-back items
    run_frames(180);
    idle_off = 1'b0;
    set_fade(16'($urandom_range(2, 2000)));
    run_frames(200);
    set_fade(16'd0);
    run_frames(180);
    set_fade(16'hFFFF);
    run_frames(180);
  endtask

  task automatic test_output_stall();
    set_fade(16'($urandom));
    hold_off_cycles = 2000;   // receiver stops while items keep coming
    run_frames(200);
    drain();
  endtask

  // -------------------------------------------------------------------------
  // Receiver: random tready, with a long hold-off on request
  // -------------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_off_cycles > 0) begin
      m_tready <= 1'b0;
      hold_off_cycles <= hold_off_cycles - 1;
    end else if (idle_off) begin
      m_tready <= 1'b1;
    end else begin
      m_tready <= (pick_gap() == 0);
    end
  end

  // Result checker
  always @(posedge clk) begin
    fade_result_t exp_r;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result opacity=%0d needs_animation=%0d", m_tdata, m_tuser);
        error_count++;
      end else begin
        exp_r = expected_results.pop_front();
        if (m_tdata !== exp_r.opacity) begin
          $error("opacity expected %0d actual %0d", exp_r.opacity, m_tdata);
          error_count++;
        end
        if (m_tuser !== exp_r.anim) begin
          $error("needs_animation expected %0d actual %0d", exp_r.anim, m_tuser);
          error_count++;
        end
      end
    end
  end

  // Watchdog: cycles in a row with no handshake on either side
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL zoom_level_fade_table_unit");
      $finish;
    end
  end

  initial begin
    for (int z = 0; z < NUM_LEVELS; z++) begin
      lvl_opacity[z] = '0;
      lvl_start[z]   = '0;
      lvl_stamp[z]   = '0;
    end
    awaiting_first   = 1'b1;
    prev_level       = '0;
    zoom_change_time = '0;
    latest_time      = '0;
    fade_len         = FADE_RESET;

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reads_after_reset();
    test_first_record();
    test_directed_extremes();
    test_fade_settings();
    test_output_stall();

    drain();
    repeat (20) @(posedge clk);
    if (error_count == 0 && expected_results.size() == 0)
      $display("PASS zoom_level_fade_table_unit");
    else
      $display("FAIL zoom_level_fade_table_unit");
    $finish;
  end

endmodule

`default_nettype wire

/* filelist.f */
rtl/core/zlft_pkg.sv
rtl/core/zoom_level_fade_table_unit.sv
tb/tb_top.sv
